// ----- rtl/core/assert_macros.svh -----
// assertion helpers for the core datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- rtl/core/fbse_pkg.sv -----
package fbse_pkg;

   localparam int DEF_FRAME_WIDTH  = 128;
   localparam int DEF_FRAME_HEIGHT = 128;
   localparam int DEF_PIXEL_BITS   = 32;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_SCROLL = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_LEFT  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_DOWN  = 2'd3
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type      operation;
      dir_type     direction;
      logic [7:0]  shift_amount;
      logic [6:0]  pixel_x;
      logic [6:0]  pixel_y;
      logic [31:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [7:0]  stale_x_start;
      logic [7:0]  stale_y_start;
      logic [7:0]  stale_x_end;
      logic [7:0]  stale_y_end;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic copy;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic scroll_op;
      logic scroll_empty;
      logic last_step;
      logic rsp_free;
   } status_type;

endpackage

// ----- rtl/core/fbse_ram.sv -----
module fbse_ram #(
   parameter int WIDTH = fbse_pkg::DEF_PIXEL_BITS,
   parameter int DEPTH = fbse_pkg::DEF_FRAME_WIDTH * fbse_pkg::DEF_FRAME_HEIGHT,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/fbse_ctrl.sv -----
module fbse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbse_pkg::status_type   status,
   output fbse_pkg::cmd_type      cmd
);

   fbse_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         fbse_pkg::ST_IDLE: begin
            req_stall  = !status.rsp_free;
            cmd.accept = req_valid && status.rsp_free;
            if (cmd.accept) begin
               if (status.scroll_op && !status.scroll_empty) begin
                  state_in = fbse_pkg::ST_COPY;
               end else begin
                  state_in = fbse_pkg::ST_DONE;
               end
            end
         end
         fbse_pkg::ST_COPY: begin
            cmd.copy = 1'b1;
            if (status.last_step) begin
               state_in = fbse_pkg::ST_DONE;
            end
         end
         fbse_pkg::ST_DONE: begin
            cmd.load = 1'b1;
            state_in = fbse_pkg::ST_IDLE;
         end
         default: begin
            state_in = fbse_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/fbse_datapath.sv -----
`include "assert_macros.svh"

module fbse_datapath #(
   parameter int FRAME_WIDTH  = fbse_pkg::DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = fbse_pkg::DEF_FRAME_HEIGHT,
   parameter int PIXEL_BITS   = fbse_pkg::DEF_PIXEL_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fbse_pkg::req_type      req_word,
   input  fbse_pkg::cmd_type      cmd,
   output fbse_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbse_pkg::rsp_type      rsp_word
);

   localparam int CW   = $clog2(FRAME_WIDTH);
   localparam int RW   = $clog2(FRAME_HEIGHT);
   localparam int AW   = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
   localparam int MAXD = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int DW   = $clog2(MAXD + 1);
   localparam int SHW  = (DW > 8) ? DW : 8;
   localparam logic [DW-1:0] W_D = DW'(FRAME_WIDTH);
   localparam logic [DW-1:0] H_D = DW'(FRAME_HEIGHT);

   // accept-time decode
   logic            horiz, in_range, scroll_empty;
   logic [DW-1:0]   dim, shift_sat;
   logic [SHW-1:0]  shift_w;
   logic [AW-1:0]   pix_addr;
   logic [63:0]     pix_wide;
   logic [7:0]      xs, ys, xe, ye;
   logic [CW-1:0]   col_first, col_last;
   logic [RW-1:0]   row_first, row_last;
   logic            col_dec, row_dec, sub;
   logic [AW-1:0]   offset;

   // latched item state
   fbse_pkg::op_type op_ff;
   logic             rd_ok_ff;
   logic [7:0]       xs_ff, ys_ff, xe_ff, ye_ff;
   logic [CW-1:0]    col_ff, col_in, col_first_ff, col_last_ff;
   logic [RW-1:0]    row_ff, row_in, row_last_ff;
   logic             col_dec_ff, row_dec_ff, sub_ff;
   logic [AW-1:0]    offset_ff;

   // copy pipeline
   logic [AW-1:0]    dest_addr, src_addr, wr_addr_ff;
   logic             wr_pend_ff;
   logic             last_step;

   // frame store ports
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [PIXEL_BITS-1:0] ram_wdata, ram_rdata;
   logic [63:0]           rd_wide;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   fbse_pkg::rsp_type rsp_word_ff, rsp_word_in;

   always_comb begin
      horiz   = (req_word.direction == fbse_pkg::DIR_LEFT) ||
                (req_word.direction == fbse_pkg::DIR_RIGHT);
      dim     = horiz ? W_D : H_D;
      shift_w = SHW'(req_word.shift_amount);
      shift_sat = (shift_w > SHW'(dim)) ? dim : DW'(shift_w);
      scroll_empty = (shift_sat == '0) || (shift_sat == dim);

      in_range = (32'(req_word.pixel_x) < FRAME_WIDTH) &&
                 (32'(req_word.pixel_y) < FRAME_HEIGHT);
      pix_addr = AW'(32'(req_word.pixel_y) * FRAME_WIDTH + 32'(req_word.pixel_x));
      pix_wide = {32'd0, req_word.pixel_value};

      xs = '0;
      ys = '0;
      xe = 8'(W_D);
      ye = 8'(H_D);
      col_first = '0;
      col_last  = CW'(W_D - DW'(1));
      row_first = '0;
      row_last  = RW'(H_D - DW'(1));
      col_dec   = 1'b0;
      row_dec   = 1'b0;
      sub       = 1'b0;
      offset    = AW'(shift_sat);
      unique case (req_word.direction)
         fbse_pkg::DIR_LEFT: begin
            xs       = 8'(W_D - shift_sat);
            col_last = CW'(W_D - DW'(1) - shift_sat);
         end
         fbse_pkg::DIR_RIGHT: begin
            xe        = 8'(shift_sat);
            col_first = CW'(W_D - DW'(1));
            col_last  = CW'(shift_sat);
            col_dec   = 1'b1;
            sub       = 1'b1;
         end
         fbse_pkg::DIR_UP: begin
            ye        = 8'(shift_sat);
            row_first = RW'(H_D - DW'(1));
            row_last  = RW'(shift_sat);
            row_dec   = 1'b1;
            sub       = 1'b1;
            offset    = AW'(32'(shift_sat) * FRAME_WIDTH);
         end
         fbse_pkg::DIR_DOWN: begin
            ys       = 8'(H_D - shift_sat);
            row_last = RW'(H_D - DW'(1) - shift_sat);
            offset   = AW'(32'(shift_sat) * FRAME_WIDTH);
         end
      endcase
   end

   always_comb begin
      dest_addr = AW'(32'(row_ff) * FRAME_WIDTH + 32'(col_ff));
      src_addr  = sub_ff ? (dest_addr - offset_ff) : (dest_addr + offset_ff);
      last_step = (col_ff == col_last_ff) && (row_ff == row_last_ff);
   end

   // scan counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      priority if (cmd.accept) begin
         col_in = col_first;
         row_in = row_first;
      end else if (cmd.copy) begin
         if (col_ff == col_last_ff) begin
            col_in = col_first_ff;
            row_in = row_dec_ff ? (row_ff - RW'(1)) : (row_ff + RW'(1));
         end else begin
            col_in = col_dec_ff ? (col_ff - CW'(1)) : (col_ff + CW'(1));
         end
      end else if (cmd.load) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         wr_pend_ff <= cmd.copy;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= req_word.operation;
         rd_ok_ff     <= in_range;
         xs_ff        <= xs;
         ys_ff        <= ys;
         xe_ff        <= xe;
         ye_ff        <= ye;
         col_first_ff <= col_first;
         col_last_ff  <= col_last;
         row_last_ff  <= row_last;
         col_dec_ff   <= col_dec;
         row_dec_ff   <= row_dec;
         sub_ff       <= sub;
         offset_ff    <= offset;
      end
      if (cmd.copy) begin
         wr_addr_ff <= dest_addr;
      end
   end

   // store port muxing: copy write lands in the cycle after its read
   always_comb begin
      ram_we    = wr_pend_ff ||
                  (cmd.accept && (req_word.operation == fbse_pkg::OP_WRITE) && in_range);
      ram_waddr = wr_pend_ff ? wr_addr_ff : pix_addr;
      ram_wdata = wr_pend_ff ? ram_rdata : PIXEL_BITS'(pix_wide);
      ram_re    = cmd.copy ||
                  (cmd.accept && (req_word.operation == fbse_pkg::OP_READ));
      ram_raddr = cmd.copy ? src_addr : pix_addr;
      rd_wide   = 64'(ram_rdata);
   end

   fbse_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (FRAME_WIDTH * FRAME_HEIGHT)
   ) u_frame (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // result
   always_comb begin
      rsp_word_in = '0;
      unique case (op_ff)
         fbse_pkg::OP_READ: begin
            rsp_word_in.read_value = rd_ok_ff ? rd_wide[31:0] : 32'd0;
         end
         fbse_pkg::OP_SCROLL: begin
            rsp_word_in.stale_x_start = xs_ff;
            rsp_word_in.stale_y_start = ys_ff;
            rsp_word_in.stale_x_end   = xe_ff;
            rsp_word_in.stale_y_end   = ye_ff;
         end
         fbse_pkg::OP_WRITE, fbse_pkg::OP_NOP: begin
            rsp_word_in = '0;
         end
      endcase
      rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      status.scroll_op    = (req_word.operation == fbse_pkg::OP_SCROLL);
      status.scroll_empty = scroll_empty;
      status.last_step    = last_step;
      status.rsp_free     = !rsp_valid_ff || !rsp_stall;
   end

   `ASSERT_NEVER(a_write_clash, clock, reset, wr_pend_ff && cmd.accept, "copy write collides with new item")
   `ASSERT_AT(a_copy_hazard, clock, reset, (cmd.copy && wr_pend_ff) |-> (src_addr != wr_addr_ff), "copy reads pixel being written")
   `ASSERT_AT(a_rsp_overwrite, clock, reset, cmd.load |-> !(rsp_valid_ff && rsp_stall), "result overwrites a waiting word")

endmodule

// ----- rtl/core/framebuffer_scroll_engine_core.sv -----
// frame store of FRAME_WIDTH x FRAME_HEIGHT pixels with pixel write, pixel read
// and in-place scroll, one result word per request word
// request channel: req_valid / req_stall / req_word, taken when valid and not stall
// result channel: rsp_valid / rsp_stall / rsp_word, one registered output word
// write, read and no-op: accept moves the sequencer straight to its load state,
//   which registers the result word; no new request is taken before that load
// scroll: one pixel copied per cycle through the single-port-pair frame RAM, N
//   pixels in all, N = (FRAME_WIDTH - shift) * FRAME_HEIGHT for left and
//   right, FRAME_WIDTH * (FRAME_HEIGHT - shift) for up and down, N = 0 for a zero
//   or full shift; each pixel is written from the registered read of its source
// a scroll result carries the stale rectangle to redraw; reads carry the pixel
// reset clears the controller, the copy pipeline and the result valid; frame
//   pixels are undefined until written and need no clearing pass
// while the receiver stalls, the result word holds and no new request is taken
//   until that word leaves the output register
module framebuffer_scroll_engine_core #(
   parameter int FRAME_WIDTH  = fbse_pkg::DEF_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = fbse_pkg::DEF_FRAME_HEIGHT,
   parameter int PIXEL_BITS   = fbse_pkg::DEF_PIXEL_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fbse_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fbse_pkg::rsp_type rsp_word
);

   // command and status between sequencer and datapath
   fbse_pkg::cmd_type    cmd;
   fbse_pkg::status_type status;

   // sequencer: idle, copy sweep, result load
   fbse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: scan counters, address math, frame RAM, output register
   fbse_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .PIXEL_BITS   (PIXEL_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fbse_pkg::*;

   // frame geometry follows the package defaults the core is built with
   localparam int FW         = DEF_FRAME_WIDTH;
   localparam int FH         = DEF_FRAME_HEIGHT;
   localparam int PIX_COUNT  = FW * FH;
   // a scroll by one moves all but one column or row of pixels with no handshake, so leave plenty of room
   localparam int IDLE_LIMIT = 100000;
   localparam int RANDOM_WORDS = 70;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   framebuffer_scroll_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // shadow copy of the frame: pixel values plus a flag per pixel that says
   // whether it holds a written value (scrolls carry the flag with the value)
   logic [31:0] frame_image   [PIX_COUNT];
   bit          frame_written [PIX_COUNT];

   rsp_type expected_rsp [$];   // result words still owed by the core, oldest first
   rsp_type rsp_want;
   int      error_count = 0;
   int      words_sent  = 0;    // accepted request words, no-ops left out
   bit      quiet       = 1'b0; // when set, neither side idles
   int      stall_left  = 0;
   int      stall_len;
   int      idle_cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- helpers

   // gap length for either side: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pix_index(int x, int y);
      return y * FW + x;
   endfunction

   // left and right move along the columns, up and down along the rows
   function automatic int shift_limit(dir_type dir);
      return (dir == DIR_LEFT || dir == DIR_RIGHT) ? FW : FH;
   endfunction

   function automatic int clamp_shift(dir_type dir, logic [7:0] amount);
      int lim;
      lim = shift_limit(dir);
      return (amount > lim) ? lim : int'(amount);
   endfunction

   // every field random, so that unused fields still toggle all their bits
   function automatic req_type random_word();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(req_type)-1:0];
   endfunction

   function automatic req_type make_write(int x, int y, logic [31:0] value);
      req_type w;
      w = random_word();
      w.operation   = OP_WRITE;
      w.pixel_x     = 7'(x);
      w.pixel_y     = 7'(y);
      w.pixel_value = value;
      return w;
   endfunction

   function automatic req_type make_read(int x, int y);
      req_type w;
      w = random_word();
      w.operation = OP_READ;
      w.pixel_x   = 7'(x);
      w.pixel_y   = 7'(y);
      return w;
   endfunction

   function automatic req_type make_scroll(dir_type dir, logic [7:0] amount);
      req_type w;
      w = random_word();
      w.operation    = OP_SCROLL;
      w.direction    = dir;
      w.shift_amount = amount;
      return w;
   endfunction

   function automatic void copy_pixel(int dst, int src);
      frame_image[dst]   = frame_image[src];
      frame_written[dst] = frame_written[src];
   endfunction

   // in-place move, each direction scanned so that no source is overwritten first
   function automatic void scroll_image(dir_type dir, int s);
      int x, y;
      case (dir)
         DIR_LEFT: begin
            for (y = 0; y < FH; y++)
               for (x = 0; x + s < FW; x++) copy_pixel(pix_index(x, y), pix_index(x + s, y));
         end
         DIR_RIGHT: begin
            for (y = 0; y < FH; y++)
               for (x = FW; x > s; x--) copy_pixel(pix_index(x - 1, y), pix_index(x - 1 - s, y));
         end
         DIR_UP: begin
            for (y = FH; y > s; y--)
               for (x = 0; x < FW; x++) copy_pixel(pix_index(x, y - 1), pix_index(x, y - 1 - s));
         end
         default: begin
            for (y = 0; y + s < FH; y++)
               for (x = 0; x < FW; x++) copy_pixel(pix_index(x, y), pix_index(x, y + s));
         end
      endcase
   endfunction

   // applies one accepted word to the shadow frame and gives the result word it owes
   function automatic rsp_type frame_result(req_type w);
      rsp_type r;
      int      s;
      r = '0;
      case (w.operation)
         OP_WRITE: begin
            if (w.pixel_x < FW && w.pixel_y < FH) begin
               frame_image[pix_index(w.pixel_x, w.pixel_y)]   = w.pixel_value;
               frame_written[pix_index(w.pixel_x, w.pixel_y)] = 1'b1;
            end
         end
         OP_READ: begin
            if (w.pixel_x < FW && w.pixel_y < FH)
               r.read_value = frame_image[pix_index(w.pixel_x, w.pixel_y)];
         end
         OP_SCROLL: begin
            s = clamp_shift(w.direction, w.shift_amount);
            scroll_image(w.direction, s);
            // stale rectangle is the band that had no source
            case (w.direction)
               DIR_LEFT: begin
                  r.stale_x_start = 8'(FW - s);
                  r.stale_x_end   = 8'(FW);
                  r.stale_y_end   = 8'(FH);
               end
               DIR_RIGHT: begin
                  r.stale_x_end = 8'(s);
                  r.stale_y_end = 8'(FH);
               end
               DIR_UP: begin
                  r.stale_x_end = 8'(FW);
                  r.stale_y_end = 8'(s);
               end
               default: begin
                  r.stale_y_start = 8'(FH - s);
                  r.stale_x_end   = 8'(FW);
                  r.stale_y_end   = 8'(FH);
               end
            endcase
         end
         default: ;   // no-op: all fields zero
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // drives one request word after a random gap and waits until it is taken;
   // valid stays high afterwards so back-to-back words need no extra edge
   task automatic send_word(req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(frame_result(w));
      if (w.operation != OP_NOP) words_sent++;
   endtask

   // sender holds off until every owed result word is back
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // reads a pixel that is known to hold a written value; writes one first if none does
   task automatic read_known_pixel();
      int count, pick, i;
      count = 0;
      for (i = 0; i < PIX_COUNT; i++) count += frame_written[i];
      if (count == 0) begin
         send_word(make_write($urandom_range(0, FW - 1), $urandom_range(0, FH - 1), $urandom));
         for (i = 0; i < PIX_COUNT; i++) count += frame_written[i];
      end
      pick = $urandom_range(0, count - 1);
      for (i = 0; i < PIX_COUNT; i++) begin
         if (frame_written[i]) begin
            if (pick == 0) begin
               send_word(make_read(i % FW, i / FW));
               break;
            end
            pick--;
         end
      end
   endtask

   // mostly large shifts so the copy is short; small shifts are rare and slow
   function automatic logic [7:0] pick_random_shift();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'(FW);
      if (r == 2) return 8'($urandom_range(129, 255));
      if (r == 3) return 8'($urandom_range(1, 8));
      return 8'($urandom_range(96, 127));
   endfunction

   // writes pixels where the scroll will pick them up, scrolls, then reads
   // some of the places they landed plus up to two other written pixels
   task automatic run_scroll_sequence();
      dir_type    dir;
      logic [7:0] amount;
      int         s, lim, k, i, x, y, reads;
      int         dest_x [6];
      int         dest_y [6];
      dir    = dir_type'($urandom_range(0, 3));
      amount = pick_random_shift();
      s      = clamp_shift(dir, amount);
      lim    = shift_limit(dir);
      k      = $urandom_range(1, 6);
      for (i = 0; i < k; i++) begin
         x = $urandom_range(0, FW - 1);
         y = $urandom_range(0, FH - 1);
         dest_x[i] = x;
         dest_y[i] = y;
         // with a partial shift put the pixel inside the moving band
         if (s > 0 && s < lim) begin
            case (dir)
               DIR_LEFT: begin
                  x = $urandom_range(s, FW - 1);
                  dest_x[i] = x - s;
               end
               DIR_RIGHT: begin
                  x = $urandom_range(0, FW - 1 - s);
                  dest_x[i] = x + s;
               end
               DIR_UP: begin
                  y = $urandom_range(0, FH - 1 - s);
                  dest_y[i] = y + s;
               end
               default: begin
                  y = $urandom_range(s, FH - 1);
                  dest_y[i] = y - s;
               end
            endcase
         end
         send_word(make_write(x, y, $urandom));
      end
      send_word(make_scroll(dir, amount));
      for (i = 0; i < k; i++)
         if ($urandom_range(0, 3) != 0) send_word(make_read(dest_x[i], dest_y[i]));
      reads = $urandom_range(0, 2);
      repeat (reads) read_known_pixel();
   endtask

   // broken or stray traffic: lone writes, reads, no-ops and bare scrolls
   task automatic send_noise_word();
      req_type w;
      case ($urandom_range(0, 3))
         0: begin
            w = random_word();
            w.operation = OP_NOP;
            send_word(w);
         end
         1: send_word(make_write($urandom_range(0, FW - 1), $urandom_range(0, FH - 1), $urandom));
         2: read_known_pixel();
         default: send_word(make_scroll(dir_type'($urandom_range(0, 3)), pick_random_shift()));
      endcase
   endtask

   // ------------------------------------------------------------------ tests

   // corner pixels with extreme and alternating values, then a no-op
   task automatic test_pixel_extremes();
      req_type w;
      send_word(make_write(0, 0, 32'h0000_0000));
      send_word(make_write(FW - 1, FH - 1, 32'hFFFF_FFFF));
      send_word(make_write(FW - 1, 0, 32'hAAAA_AAAA));
      send_word(make_write(0, FH - 1, 32'h5555_5555));
      send_word(make_read(0, 0));
      send_word(make_read(FW - 1, FH - 1));
      send_word(make_read(FW - 1, 0));
      send_word(make_read(0, FH - 1));
      // a no-op with every other bit set still owes an all-zero word
      w = '1;
      w.operation = OP_NOP;
      send_word(w);
      wait_all_results();
   endtask

   // zero, full and oversized shifts, a one-column move and the slow one-step moves
   task automatic test_scroll_special_cases();
      send_word(make_scroll(DIR_LEFT, 8'd0));       // nothing moves, empty stale area
      send_word(make_read(FW - 1, FH - 1));
      send_word(make_scroll(DIR_RIGHT, 8'(FW)));    // full shift marks the whole frame
      send_word(make_scroll(DIR_UP, 8'd255));       // saturates to the frame height
      send_word(make_scroll(DIR_DOWN, 8'd200));
      send_word(make_scroll(DIR_LEFT, 8'(FW - 1))); // last column lands in column zero
      send_word(make_read(0, 0));
      send_word(make_read(FW - 1, 0));              // no source, keeps its value
      send_word(make_scroll(DIR_DOWN, 8'd1));
      send_word(make_read(0, FH - 2));
      send_word(make_scroll(DIR_UP, 8'd1));
      send_word(make_read(0, FH - 1));
      send_word(make_scroll(DIR_RIGHT, 8'd1));
      send_word(make_read(1, FH - 1));              // bottom-left pixel moved one column
      wait_all_results();
   endtask

   task automatic test_random_traffic();
      int target;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         quiet = ($urandom_range(0, 6) == 0);   // some stretches run flat out
         if ($urandom_range(0, 4) != 0) run_scroll_sequence();
         else send_noise_word();
         if ($urandom_range(0, 7) == 0) wait_all_results();
      end
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------- processes

   // receiver: stall bursts of random length, none while quiet
   always @(posedge clock) begin
      if (reset || quiet) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_len = pick_gap();
         stall_left = (stall_len > 0) ? stall_len - 1 : 0;
         rsp_stall <= (stall_len > 0);
      end
   end

   // every result word taken is checked against the oldest owed word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result word with none owed", rsp_word.read_value, '0);
         end else begin
            rsp_want = expected_rsp.pop_front();
            if (rsp_word.read_value !== rsp_want.read_value)
               report_mismatch("read_value", rsp_word.read_value, rsp_want.read_value);
            if (rsp_word.stale_x_start !== rsp_want.stale_x_start)
               report_mismatch("stale_x_start", rsp_word.stale_x_start, rsp_want.stale_x_start);
            if (rsp_word.stale_y_start !== rsp_want.stale_y_start)
               report_mismatch("stale_y_start", rsp_word.stale_y_start, rsp_want.stale_y_start);
            if (rsp_word.stale_x_end !== rsp_want.stale_x_end)
               report_mismatch("stale_x_end", rsp_word.stale_x_end, rsp_want.stale_x_end);
            if (rsp_word.stale_y_end !== rsp_want.stale_y_end)
               report_mismatch("stale_y_end", rsp_word.stale_y_end, rsp_want.stale_y_end);
         end
      end
   end

   // watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_pixel_extremes();
      test_scroll_special_cases();
      test_random_traffic();
      wait_all_results();
      // short tail in case the core sends a word nobody asked for
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/fbse_pkg.sv
rtl/core/fbse_ram.sv
rtl/core/fbse_ctrl.sv
rtl/core/fbse_datapath.sv
rtl/core/framebuffer_scroll_engine_core.sv
tb/tb.sv
